### rtl/core/shortest_queue_dispatch_priority_serve_macros.svh
// Assertion macros shared by the dispatcher RTL.
// Needs a clk and an active-high rst in the scope of each use.
`ifndef SHORTEST_QUEUE_DISPATCH_PRIORITY_SERVE_MACROS_SVH
`define SHORTEST_QUEUE_DISPATCH_PRIORITY_SERVE_MACROS_SVH

`ifndef SYNTHESIS
`define SQD_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sqd check failed");
`define SQD_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqd check failed");
`define SQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqd check failed");
`else
`define SQD_ASSERT_ALWAYS(label, expr)
`define SQD_ASSERT_IMPLY(label, ante, cons)
`define SQD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/sqd_pkg.sv
// Package for the shortest-queue dispatcher: codes, fixed field widths,
// sequencer state and the control structs. No dependencies.
package sqd_pkg;

  localparam int ACTION_W   = 2;
  localparam int STATION_W  = 3;
  localparam int STATUS_W   = 2;
  localparam int STREAK_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SCOUNT_W   = 4;
  localparam int THRESH_W   = 5;

  localparam logic [STREAK_W-1:0] STREAK_MAX = 4'd15;

  localparam logic [ACTION_W-1:0] ACT_ORDINARY = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PRIORITY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SERVE    = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DROP  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STATION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAK_LIMIT  = 2'd2;

  localparam logic [SCOUNT_W-1:0] RST_STATION_COUNT = 4'd1;
  localparam logic [THRESH_W-1:0] RST_THRESHOLD     = 5'd5;
  localparam logic [STREAK_W-1:0] RST_STREAK_LIMIT  = 4'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PLACE,
    ST_DECIDE,
    ST_FETCH,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic in_valid;
    logic act_arrival;
    logic act_serve;
    logic search_last;
    logic serve_ok;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic in_ready;
    logic search_step;
    logic place;
    logic decide;
    logic fetch;
    logic load_out;
  } seq_ctl_t;

endpackage

### rtl/core/sqd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sqd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/sqd_ctl.sv
// Sequencer for the dispatcher: steps one word through search and place for an
// arrival, or decide and fetch for a serve, then report. Depends on sqd_pkg.
module sqd_ctl (
  input  logic               clk,
  input  logic               rst,
  input  sqd_pkg::seq_stat_t stat,
  output sqd_pkg::state_t    state,
  output sqd_pkg::seq_ctl_t  ctl
);

  sqd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sqd_pkg::ST_IDLE: begin
        if (stat.in_valid) begin
          if (stat.act_arrival) begin
            state_next = sqd_pkg::ST_SEARCH;
          end else if (stat.act_serve) begin
            state_next = sqd_pkg::ST_DECIDE;
          end else begin
            state_next = sqd_pkg::ST_REPORT;
          end
        end
      end
      sqd_pkg::ST_SEARCH: begin
        if (stat.search_last) begin
          state_next = sqd_pkg::ST_PLACE;
        end
      end
      sqd_pkg::ST_PLACE:  state_next = sqd_pkg::ST_REPORT;
      sqd_pkg::ST_DECIDE: begin
        state_next = stat.serve_ok ? sqd_pkg::ST_FETCH : sqd_pkg::ST_REPORT;
      end
      sqd_pkg::ST_FETCH:  state_next = sqd_pkg::ST_REPORT;
      sqd_pkg::ST_REPORT: begin
        if (stat.out_free) begin
          state_next = sqd_pkg::ST_IDLE;
        end
      end
      default: state_next = sqd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      sqd_pkg::ST_IDLE:   ctl.in_ready = 1'b1;
      sqd_pkg::ST_SEARCH: ctl.search_step = 1'b1;
      sqd_pkg::ST_PLACE:  ctl.place = 1'b1;
      sqd_pkg::ST_DECIDE: ctl.decide = 1'b1;
      sqd_pkg::ST_FETCH:  ctl.fetch = 1'b1;
      sqd_pkg::ST_REPORT: ctl.load_out = stat.out_free;
      default:            ctl = '0;
    endcase
  end

endmodule

### rtl/core/shortest_queue_dispatch_priority_serve.sv
// Top level of the shortest-queue dispatcher with priority-aware serving.
// Depends on sqd_pkg, sqd_ctl, sqd_ram and the assertion macro header.
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: station; tuser: action
// m_axis    out  m_axis_tvalid/tready    tdata: chosen_station, request_id;
//                                         tuser: status, served_priority
// cfg       in   cfg_we                  cfg_index, cfg_data
//
// An arrival searches the enabled stations (the shared compare unit scans one
// station fill per cycle), then places; a serve decides and fetches, an empty serve
// only decides, and an unknown action goes straight to the report state.
// s_axis_tready is high only while no word is in flight; a stalled result waits in
// the output register while the next word is already accepted and worked on.
// rst is synchronous; fills, heads, streaks and the id counter clear at once.
`include "shortest_queue_dispatch_priority_serve_macros.svh"

module shortest_queue_dispatch_priority_serve #(
  parameter int STATIONS    = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [2:0] station, rest zero
  input  logic [7:0] s_axis_tdata,
  // [1:0] action
  input  logic [sqd_pkg::ACTION_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [2:0] chosen_station, then request_id, then zero fill
  output logic [((sqd_pkg::STATION_W + ID_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // [1:0] status, [2] served_priority
  output logic [sqd_pkg::STATUS_W:0] m_axis_tuser,
  input  logic cfg_we,
  input  logic [sqd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sqd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int OUT_DATA_W = ((sqd_pkg::STATION_W + ID_BITS + 7) / 8) * 8;
  localparam int STN_W   = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int CNT_W   = ($clog2(STATIONS + 1) > sqd_pkg::SCOUNT_W) ?
                           $clog2(STATIONS + 1) : sqd_pkg::SCOUNT_W;
  localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = FILL_W + 1;
  localparam int CMPF_W  = (FILL_W > sqd_pkg::THRESH_W) ? FILL_W : sqd_pkg::THRESH_W;
  localparam int RAM_DEPTH = STATIONS * QUEUE_DEPTH;
  localparam int ADDR_W  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // configuration
  logic [sqd_pkg::SCOUNT_W-1:0] station_count;
  logic [sqd_pkg::THRESH_W-1:0] long_queue_threshold;
  logic [sqd_pkg::STREAK_W-1:0] streak_limit;

  // per-station bookkeeping
  logic [FILL_W-1:0]            ord_fill [STATIONS];
  logic [FILL_W-1:0]            pri_fill [STATIONS];
  logic [HEAD_W-1:0]            ord_head [STATIONS];
  logic [HEAD_W-1:0]            pri_head [STATIONS];
  logic [sqd_pkg::STREAK_W-1:0] streak   [STATIONS];
  logic [ID_BITS-1:0]           next_id;

  // word in flight
  logic [sqd_pkg::ACTION_W-1:0]  act_reg;
  logic [sqd_pkg::STATION_W-1:0] stn_reg;
  logic [STN_W-1:0]              search_idx;
  logic [STN_W-1:0]              best;
  logic [FILL_W-1:0]             best_fill;

  logic [sqd_pkg::STATUS_W-1:0]  res_status;
  logic [sqd_pkg::STATION_W-1:0] res_station;
  logic [ID_BITS-1:0]            res_id;
  logic                          res_prio;

  logic                          out_valid;
  logic [sqd_pkg::STATUS_W-1:0]  out_status;
  logic [sqd_pkg::STATION_W-1:0] out_station;
  logic [ID_BITS-1:0]            out_id;
  logic                          out_prio;

  sqd_pkg::state_t   state;
  sqd_pkg::seq_stat_t stat;
  sqd_pkg::seq_ctl_t  ctl;

  logic                          in_fire;
  logic                          is_prio;
  logic [CNT_W-1:0]              n_enabled;
  logic [STN_W-1:0]              srv_idx;
  logic [STN_W-1:0]              rd_idx;
  logic [FILL_W-1:0]             ord_f;
  logic [FILL_W-1:0]             pri_f;
  logic [HEAD_W-1:0]             ord_h;
  logic [HEAD_W-1:0]             pri_h;
  logic [sqd_pkg::STREAK_W-1:0]  streak_rd;
  logic [FILL_W-1:0]             scan_fill;
  logic                          in_range;
  logic                          serve_ok;
  logic                          take_ord_pre;
  logic                          take_pri;
  logic                          cls_prio;
  logic [HEAD_W-1:0]             cls_head;
  logic [FILL_W-1:0]             cls_fill;
  logic                          full;
  logic [SUM_W-1:0]              pos_sum;
  logic [HEAD_W-1:0]             pos;
  logic [ADDR_W-1:0]             base_addr;
  logic [ADDR_W-1:0]             waddr;
  logic [ADDR_W-1:0]             raddr;
  logic                          ord_we;
  logic                          pri_we;
  logic                          ram_re;
  logic [ID_BITS-1:0]            ord_rdata;
  logic [ID_BITS-1:0]            pri_rdata;

  assign in_fire = s_axis_tvalid && ctl.in_ready;
  assign s_axis_tready = ctl.in_ready;
  assign is_prio = (act_reg == sqd_pkg::ACT_PRIORITY);

  always_comb begin
    if (station_count == '0) begin
      n_enabled = CNT_W'(1);
    end else if (CNT_W'(station_count) > CNT_W'(STATIONS)) begin
      n_enabled = CNT_W'(STATIONS);
    end else begin
      n_enabled = CNT_W'(station_count);
    end
  end

  assign srv_idx = STN_W'(stn_reg);

  always_comb begin
    case (state)
      sqd_pkg::ST_SEARCH: rd_idx = search_idx;
      sqd_pkg::ST_PLACE:  rd_idx = best;
      default:            rd_idx = srv_idx;
    endcase
  end

  assign ord_f     = ord_fill[rd_idx];
  assign pri_f     = pri_fill[rd_idx];
  assign ord_h     = ord_head[rd_idx];
  assign pri_h     = pri_head[rd_idx];
  assign streak_rd = streak[rd_idx];
  assign scan_fill = is_prio ? pri_f : ord_f;

  // serve arbitration
  assign in_range     = CNT_W'(stn_reg) < CNT_W'(STATIONS);
  assign serve_ok     = in_range && ((ord_f != '0) || (pri_f != '0));
  assign take_ord_pre = (ord_f != '0) &&
                        (CMPF_W'(ord_f) >= CMPF_W'(long_queue_threshold)) &&
                        (streak_rd <= streak_limit);
  assign take_pri     = !take_ord_pre && (pri_f != '0);

  // shared wrap adder: head + fill on a place, head + 1 on a pop
  assign cls_prio = ctl.place ? is_prio : take_pri;
  assign cls_head = cls_prio ? pri_h : ord_h;
  assign cls_fill = cls_prio ? pri_f : ord_f;
  assign full     = cls_fill >= FILL_W'(QUEUE_DEPTH);
  assign pos_sum  = SUM_W'(cls_head) + (ctl.place ? SUM_W'(cls_fill) : SUM_W'(1));
  assign pos      = (pos_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    HEAD_W'(pos_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(pos_sum);

  assign base_addr = ADDR_W'(rd_idx) * ADDR_W'(QUEUE_DEPTH);
  assign waddr     = base_addr + ADDR_W'(pos);
  assign raddr     = base_addr + ADDR_W'(cls_head);
  assign ord_we    = ctl.place && !full && !is_prio;
  assign pri_we    = ctl.place && !full && is_prio;
  assign ram_re    = ctl.decide && serve_ok;

  assign stat.in_valid    = s_axis_tvalid;
  assign stat.act_arrival = (s_axis_tuser == sqd_pkg::ACT_ORDINARY) ||
                            (s_axis_tuser == sqd_pkg::ACT_PRIORITY);
  assign stat.act_serve   = (s_axis_tuser == sqd_pkg::ACT_SERVE);
  assign stat.search_last = (CNT_W'(search_idx) + CNT_W'(1)) == n_enabled;
  assign stat.serve_ok    = serve_ok;
  assign stat.out_free    = !out_valid || m_axis_tready;

  sqd_ctl u_ctl (
    .clk   (clk),
    .rst   (rst),
    .stat  (stat),
    .state (state),
    .ctl   (ctl)
  );

  sqd_ram #(.WIDTH(ID_BITS), .DEPTH(RAM_DEPTH)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (waddr),
    .wdata (next_id),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (ord_rdata)
  );

  sqd_ram #(.WIDTH(ID_BITS), .DEPTH(RAM_DEPTH)) u_pri_ram (
    .clk   (clk),
    .we    (pri_we),
    .waddr (waddr),
    .wdata (next_id),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (pri_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      station_count        <= sqd_pkg::RST_STATION_COUNT;
      long_queue_threshold <= sqd_pkg::RST_THRESHOLD;
      streak_limit         <= sqd_pkg::RST_STREAK_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        sqd_pkg::CFG_STATION_COUNT: station_count <= cfg_data[sqd_pkg::SCOUNT_W-1:0];
        sqd_pkg::CFG_THRESHOLD:     long_queue_threshold <= cfg_data;
        sqd_pkg::CFG_STREAK_LIMIT:  streak_limit <= cfg_data[sqd_pkg::STREAK_W-1:0];
        default:                    station_count <= station_count;
      endcase
    end
  end

  // per-station fills, heads and streaks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STATIONS; i++) begin
        ord_fill[i] <= '0;
        pri_fill[i] <= '0;
        ord_head[i] <= '0;
        pri_head[i] <= '0;
        streak[i]   <= '0;
      end
      next_id <= '0;
    end else if (ctl.place) begin
      next_id <= next_id + ID_BITS'(1);
      if (!full) begin
        if (is_prio) begin
          pri_fill[rd_idx] <= pri_f + FILL_W'(1);
        end else begin
          ord_fill[rd_idx] <= ord_f + FILL_W'(1);
        end
      end
    end else if (ctl.decide && serve_ok) begin
      if (take_pri) begin
        pri_head[rd_idx] <= pos;
        pri_fill[rd_idx] <= pri_f - FILL_W'(1);
        streak[rd_idx]   <= '0;
      end else begin
        ord_head[rd_idx] <= pos;
        ord_fill[rd_idx] <= ord_f - FILL_W'(1);
        if (take_ord_pre && (streak_rd != sqd_pkg::STREAK_MAX)) begin
          streak[rd_idx] <= streak_rd + sqd_pkg::STREAK_W'(1);
        end
      end
    end
  end

  // word in flight and its result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_reg     <= s_axis_tuser;
      stn_reg     <= s_axis_tdata[sqd_pkg::STATION_W-1:0];
      search_idx  <= '0;
      res_status  <= sqd_pkg::STAT_EMPTY;
      res_station <= '0;
      res_id      <= '0;
      res_prio    <= 1'b0;
    end
    if (ctl.search_step) begin
      if ((search_idx == '0) || (scan_fill < best_fill)) begin
        best      <= search_idx;
        best_fill <= scan_fill;
      end
      search_idx <= search_idx + STN_W'(1);
    end
    if (ctl.place) begin
      res_status  <= full ? sqd_pkg::STAT_DROP : sqd_pkg::STAT_DONE;
      res_station <= sqd_pkg::STATION_W'(best);
      res_id      <= next_id;
      res_prio    <= is_prio;
    end
    if (ctl.decide) begin
      res_station <= stn_reg;
      if (serve_ok) begin
        res_status <= sqd_pkg::STAT_DONE;
        res_prio   <= take_pri;
      end
    end
    if (ctl.fetch) begin
      res_id <= res_prio ? pri_rdata : ord_rdata;
    end
  end

  // output register; holds while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status  <= res_status;
      out_station <= res_station;
      out_id      <= res_id;
      out_prio    <= res_prio;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_id, out_station});
  assign m_axis_tuser  = {out_prio, out_status};

  `SQD_ASSERT_IMPLY(a_search_in_bounds, state == sqd_pkg::ST_SEARCH, CNT_W'(search_idx) < n_enabled)
  `SQD_ASSERT_NEXT(a_id_advance, ctl.place, next_id == ID_BITS'($past(next_id) + ID_BITS'(1)))
  `SQD_ASSERT_IMPLY(a_fill_bound, ctl.place || ctl.decide, (ord_f <= FILL_W'(QUEUE_DEPTH)) && (pri_f <= FILL_W'(QUEUE_DEPTH)))
  `SQD_ASSERT_IMPLY(a_pop_nonempty, ctl.decide && serve_ok && take_pri, pri_f != '0)

endmodule

### dv/tb_shortest_queue_dispatch_priority_serve.sv
// Self-checking testbench for shortest_queue_dispatch_priority_serve.
// Needs sqd_pkg and the RTL of the block. A scoreboard class predicts every
// result and checks each one in order.
`timescale 1ns / 1ps

module tb_shortest_queue_dispatch_priority_serve;

  localparam int NUM_STATIONS = 8;
  localparam int FIFO_DEPTH   = 16;
  localparam int RID_W        = 16;
  localparam int RESULT_W     = ((sqd_pkg::STATION_W + RID_W + 7) / 8) * 8;
  localparam logic [sqd_pkg::ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam int CLASS_ORD = 0;
  localparam int CLASS_PRI = 1;

  typedef struct packed {
    logic [sqd_pkg::STATUS_W-1:0]  status;
    logic [sqd_pkg::STATION_W-1:0] station;
    logic [RID_W-1:0]              rid;
    logic                          prio;
  } dispatch_result_t;

  class dispatch_scoreboard;
    bit [RID_W-1:0]  id_mem [2][NUM_STATIONS][FIFO_DEPTH];
    bit [3:0]        head [2][NUM_STATIONS];
    bit [4:0]        fill [2][NUM_STATIONS];
    bit [sqd_pkg::STREAK_W-1:0] streak [NUM_STATIONS];
    bit [RID_W-1:0]  next_id;
    bit [sqd_pkg::SCOUNT_W-1:0] station_count;
    bit [sqd_pkg::THRESH_W-1:0] threshold;
    bit [sqd_pkg::STREAK_W-1:0] streak_limit;
    dispatch_result_t expected_q[$];
    int errors;
    int results_seen;

    function new();
      for (int c = 0; c < 2; c++) begin
        for (int s = 0; s < NUM_STATIONS; s++) begin
          head[c][s] = '0;
          fill[c][s] = '0;
        end
      end
      for (int s = 0; s < NUM_STATIONS; s++) streak[s] = '0;
      next_id       = '0;
      station_count = sqd_pkg::RST_STATION_COUNT;
      threshold     = sqd_pkg::RST_THRESHOLD;
      streak_limit  = sqd_pkg::RST_STREAK_LIMIT;
      errors        = 0;
      results_seen  = 0;
    endfunction

    function void set_register(logic [sqd_pkg::CFG_IDX_W-1:0] index,
                               logic [sqd_pkg::CFG_DATA_W-1:0] data);
      case (index)
        sqd_pkg::CFG_STATION_COUNT: station_count = data[sqd_pkg::SCOUNT_W-1:0];
        sqd_pkg::CFG_THRESHOLD:     threshold = data[sqd_pkg::THRESH_W-1:0];
        sqd_pkg::CFG_STREAK_LIMIT:  streak_limit = data[sqd_pkg::STREAK_W-1:0];
        default: ;
      endcase
    endfunction

    function int enabled();
      if (station_count == 0) return 1;
      if (station_count > NUM_STATIONS) return NUM_STATIONS;
      return int'(station_count);
    endfunction

    function bit [RID_W-1:0] pop_id(int cls, int st);
      bit [RID_W-1:0] v;
      v = id_mem[cls][st][head[cls][st]];
      head[cls][st] = head[cls][st] + 4'd1;
      fill[cls][st] = fill[cls][st] - 5'd1;
      return v;
    endfunction

    // Work out the result of one accepted word and queue it.
    function void note_word(logic [sqd_pkg::ACTION_W-1:0] action,
                            logic [sqd_pkg::STATION_W-1:0] station);
      dispatch_result_t r;
      int cls;
      int best;
      bit [3:0] slot;
      r = '0;
      r.status = sqd_pkg::STAT_EMPTY;
      if (action == sqd_pkg::ACT_ORDINARY || action == sqd_pkg::ACT_PRIORITY) begin
        cls = (action == sqd_pkg::ACT_PRIORITY) ? CLASS_PRI : CLASS_ORD;
        best = 0;
        for (int i = 1; i < enabled(); i++)
          if (fill[cls][i] < fill[cls][best]) best = i;
        r.rid = next_id;
        next_id = next_id + 1'b1;
        r.station = best[sqd_pkg::STATION_W-1:0];
        r.prio = (cls == CLASS_PRI);
        if (fill[cls][best] >= FIFO_DEPTH) begin
          r.status = sqd_pkg::STAT_DROP;
        end else begin
          slot = head[cls][best] + fill[cls][best][3:0];
          id_mem[cls][best][slot] = r.rid;
          fill[cls][best] = fill[cls][best] + 5'd1;
          r.status = sqd_pkg::STAT_DONE;
        end
      end else if (action == sqd_pkg::ACT_SERVE) begin
        r.station = station;
        if (fill[CLASS_ORD][station] != 0 || fill[CLASS_PRI][station] != 0) begin
          r.status = sqd_pkg::STAT_DONE;
          if (fill[CLASS_ORD][station] != 0 && fill[CLASS_ORD][station] >= threshold &&
              streak[station] <= streak_limit) begin
            r.rid = pop_id(CLASS_ORD, station);
            if (streak[station] < sqd_pkg::STREAK_MAX) streak[station] = streak[station] + 1'b1;
          end else if (fill[CLASS_PRI][station] != 0) begin
            r.rid = pop_id(CLASS_PRI, station);
            streak[station] = '0;
            r.prio = 1'b1;
          end else begin
            r.rid = pop_id(CLASS_ORD, station);
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, msg);
    endtask

    task check_result(dispatch_result_t got);
      dispatch_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.station !== want.station)
          report_mismatch($sformatf("chosen_station %0d, want %0d", got.station, want.station));
        if (got.rid !== want.rid)
          report_mismatch($sformatf("request_id %0d, want %0d", got.rid, want.rid));
        if (got.prio !== want.prio)
          report_mismatch($sformatf("served_priority %0d, want %0d", got.prio, want.prio));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [sqd_pkg::ACTION_W-1:0] s_axis_tuser = sqd_pkg::ACT_ORDINARY;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [RESULT_W-1:0] m_axis_tdata;
  logic [sqd_pkg::STATUS_W:0] m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [sqd_pkg::CFG_IDX_W-1:0] cfg_index = sqd_pkg::CFG_STATION_COUNT;
  logic [sqd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  dispatch_scoreboard sb;

  shortest_queue_dispatch_priority_serve #(
    .STATIONS(NUM_STATIONS),
    .QUEUE_DEPTH(FIFO_DEPTH),
    .ID_BITS(RID_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Result side: random stalls, check every accepted word.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result({m_axis_tuser[sqd_pkg::STATUS_W-1:0],
                         m_axis_tdata[sqd_pkg::STATION_W-1:0],
                         m_axis_tdata[sqd_pkg::STATION_W +: RID_W],
                         m_axis_tuser[sqd_pkg::STATUS_W]});
    end
  end

  task send_word(logic [sqd_pkg::ACTION_W-1:0] action, logic [sqd_pkg::STATION_W-1:0] station);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, station};
    s_axis_tuser  <= action;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(action, station);
  endtask

  // Hold the input until every result is back, then let the block settle.
  task drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  task apply_config(logic [sqd_pkg::CFG_DATA_W-1:0] count,
                    logic [sqd_pkg::CFG_DATA_W-1:0] thresh,
                    logic [sqd_pkg::CFG_DATA_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= sqd_pkg::CFG_STATION_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_index <= sqd_pkg::CFG_THRESHOLD;
    cfg_data  <= thresh;
    @(posedge clk);
    cfg_index <= sqd_pkg::CFG_STREAK_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(sqd_pkg::CFG_STATION_COUNT, count);
    sb.set_register(sqd_pkg::CFG_THRESHOLD, thresh);
    sb.set_register(sqd_pkg::CFG_STREAK_LIMIT, limit);
  endtask

  // Mix fill-heavy and drain-heavy stretches so fifos run full and empty.
  task run_random(int count);
    int arrive_pct;
    int roll;
    logic [sqd_pkg::ACTION_W-1:0] act;
    logic [sqd_pkg::STATION_W-1:0] st;
    arrive_pct = 50;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) arrive_pct = $urandom_range(85, 25);
      roll = $urandom_range(99);
      if (roll < 3) act = ACT_UNKNOWN;
      else if (roll < 3 + arrive_pct)
        act = $urandom_range(1) ? sqd_pkg::ACT_PRIORITY : sqd_pkg::ACT_ORDINARY;
      else act = sqd_pkg::ACT_SERVE;
      if ($urandom_range(9) < 8) st = sqd_pkg::STATION_W'($urandom_range(sb.enabled() - 1));
      else st = sqd_pkg::STATION_W'($urandom_range(NUM_STATIONS - 1));
      send_word(act, st);
    end
  endtask

  initial begin
    bit pick_pri;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 30;
    rx_idle_pct = 48;

    // Reset settings: one station, threshold 5, limit 4.
    send_word(sqd_pkg::ACT_SERVE, 3'd0);
    send_word(ACT_UNKNOWN, 3'd5);
    send_word(sqd_pkg::ACT_ORDINARY, 3'd7);
    send_word(sqd_pkg::ACT_ORDINARY, 3'd2);
    send_word(sqd_pkg::ACT_ORDINARY, 3'd0);
    send_word(sqd_pkg::ACT_PRIORITY, 3'd4);
    send_word(sqd_pkg::ACT_SERVE, 3'd0);
    send_word(sqd_pkg::ACT_SERVE, 3'd0);
    send_word(sqd_pkg::ACT_SERVE, 3'd3);
    send_word(sqd_pkg::ACT_SERVE, 3'd7);
    drain();

    // Zero count acts as one; threshold zero and limit zero.
    apply_config(5'd0, 5'd0, 5'd0);
    send_word(sqd_pkg::ACT_ORDINARY, 3'd6);
    send_word(sqd_pkg::ACT_PRIORITY, 3'd1);
    repeat (5) send_word(sqd_pkg::ACT_SERVE, 3'd0);
    drain();

    // Count above the station total saturates; lowest index wins ties.
    apply_config(5'd9, 5'd16, 5'd3);
    repeat (3) send_word(sqd_pkg::ACT_PRIORITY, 3'd0);
    repeat (2) send_word(sqd_pkg::ACT_ORDINARY, 3'd0);
    send_word(sqd_pkg::ACT_SERVE, 3'd1);
    drain();

    apply_config(5'd8, 5'd0, 5'd0);
    run_random(300);
    drain();
    apply_config(5'd2, 5'd16, 5'd15);
    run_random(300);
    drain();

    tx_idle_pct = 48;
    rx_idle_pct = 30;
    apply_config(5'h1F, 5'h1F, 5'h1F);
    run_random(300);
    drain();
    apply_config(5'($urandom_range(31)), 5'($urandom_range(31)), 5'($urandom_range(31)));
    run_random(300);
    drain();

    // Fill one station past capacity in both classes so arrivals drop.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_config(5'd1, 5'd1, 5'd15);
    pick_pri = 1'b0;
    repeat (40) begin
      send_word(pick_pri ? sqd_pkg::ACT_PRIORITY : sqd_pkg::ACT_ORDINARY,
                3'($urandom_range(7)));
      pick_pri = ~pick_pri;
    end
    // Long ordinary streak on a full station drives the streak into saturation.
    repeat (20) send_word(sqd_pkg::ACT_SERVE, 3'd0);
    run_random(300);
    drain();
    apply_config(5'd4, 5'd5, 5'd4);
    run_random(300);
    drain();

    while (sb.pending() != 0) begin
      sb.report_mismatch("expected result never arrived");
      void'(sb.expected_q.pop_front());
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sqd_pkg.sv
rtl/core/sqd_ram.sv
rtl/core/sqd_ctl.sv
rtl/core/shortest_queue_dispatch_priority_serve.sv
dv/tb_shortest_queue_dispatch_priority_serve.sv
